/* rtl/core/tile_color_statistics_defines.svh */
// Assertion macros shared by the tile color statistics RTL.
`ifndef TILE_COLOR_STATISTICS_DEFINES_SVH
`define TILE_COLOR_STATISTICS_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define TCS_ASSERT_ALWAYS(name, clk, rstn, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle, outside reset.
`define TCS_ASSERT_IMPLY(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/core/tcs_pkg.sv */
// Shared types, widths and register indexes of the tile color statistics block.
package tcs_pkg;

    localparam int NUM_COLORS_DEF    = 64;
    localparam int MAX_CELL_SIZE_DEF = 16;

    localparam int PIX_W      = 6;
    localparam int SIZE_W     = 5;
    localparam int CFG_W      = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int PCNT_W     = 9;
    localparam int CCNT_W     = 5;
    localparam int NCOL_W     = 7;
    localparam int SUM_W      = 24;
    localparam int MASK_W     = 64;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 128;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT = 2'd2;

    localparam logic [SIZE_W-1:0] CELL_SIZE_RESET = 5'd8;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic pix_accept;
        logic pix_write;
        logic cell_stats;
        logic emit_read;
        logic emit_load;
        logic empty_load;
    } tcs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cell_end;
        logic cell_empty;
        logic out_free;
        logic emit_last;
    } tcs_status_t;

endpackage

/* rtl/core/tcs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/tcs_ctrl.sv */
// Controller: sequences pixel update, cell statistics and per-color emission.
module tcs_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  tcs_pkg::tcs_status_t status,
    output tcs_pkg::tcs_cmd_t    cmd
);

    import tcs_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_PIX_WR   = 6'b000010,
        ST_STATS    = 6'b000100,
        ST_EMIT_RD  = 6'b001000,
        ST_EMIT_OUT = 6'b010000,
        ST_EMPTY    = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.pix_accept = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_PIX_WR;
                end
            end
            ST_PIX_WR: begin
                cmd.pix_write = 1'b1;
                state_next    = status.cell_end ? ST_STATS : ST_IDLE;
            end
            ST_STATS: begin
                cmd.cell_stats = 1'b1;
                state_next     = status.cell_empty ? ST_EMPTY : ST_EMIT_RD;
            end
            ST_EMIT_RD: begin
                cmd.emit_read = 1'b1;
                state_next    = ST_EMIT_OUT;
            end
            ST_EMIT_OUT: begin
                // hold until the output register frees up
                if (status.out_free) begin
                    cmd.emit_load = 1'b1;
                    state_next    = status.emit_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            ST_EMPTY: begin
                if (status.out_free) begin
                    cmd.empty_load = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

/* rtl/core/tcs_datapath.sv */
// Datapath: configuration, cell counters, presence masks, histogram RAM, output register.
`include "tile_color_statistics_defines.svh"

module tcs_datapath #(
    parameter int NUM_COLORS    = tcs_pkg::NUM_COLORS_DEF,
    parameter int MAX_CELL_SIZE = tcs_pkg::MAX_CELL_SIZE_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [tcs_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [tcs_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic [tcs_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tcs_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tuser,
    output logic                            m_tlast,
    input  tcs_pkg::tcs_cmd_t               cmd,
    output tcs_pkg::tcs_status_t            status
);

    import tcs_pkg::*;

    localparam int AW    = $clog2(NUM_COLORS);
    localparam int CNT_W = (MAX_CELL_SIZE > 1) ? $clog2(MAX_CELL_SIZE) : 1;
    localparam int RAM_W = PCNT_W + CCNT_W;
    localparam int PAD_W = M_TDATA_W - (PIX_W + PCNT_W + CCNT_W + 2 * NCOL_W + SUM_W + MASK_W);

    // configuration
    logic [PIX_W-1:0]  bg_reg;
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;

    // cell and image state
    logic [CNT_W-1:0]      row_reg, row_next;
    logic [CNT_W-1:0]      colc_reg, colc_next;
    logic [NUM_COLORS-1:0] col_pres_reg, col_pres_next;
    logic [NUM_COLORS-1:0] cell_pres_reg, cell_pres_next;
    logic [NCOL_W-1:0]     cell_cnt_reg, cell_cnt_next;
    logic [NUM_COLORS-1:0] img_pres_reg, img_pres_next;
    logic [NCOL_W-1:0]     max_reg, max_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;

    // per-pixel and per-color working registers
    logic          counted_reg, new_cell_reg, new_col_reg, cell_end_reg;
    logic [AW-1:0] pix_idx_reg;
    logic [AW-1:0] emit_color_reg;
    logic          emit_last_reg;

    // output register
    logic              out_valid_reg;
    logic [PIX_W-1:0]  out_color_reg;
    logic              out_cvalid_reg;
    logic [PCNT_W-1:0] out_pix_reg;
    logic [CCNT_W-1:0] out_col_reg;
    logic [NCOL_W-1:0] out_ccount_reg;
    logic [NCOL_W-1:0] out_max_reg;
    logic [SUM_W-1:0]  out_sum_reg;
    logic [MASK_W-1:0] out_mask_reg;
    logic              out_last_reg;

    // pixel intake logic
    logic [PIX_W-1:0]      pix;
    logic [AW-1:0]         pix_addr;
    logic                  clr;
    logic                  counted;
    logic [NUM_COLORS-1:0] pix_bit;
    logic [NUM_COLORS-1:0] cell_base, col_base;
    logic [NCOL_W-1:0]     cnt_base;
    logic [CNT_W-1:0]      row_base, colc_base;
    logic                  new_cell, new_col;
    logic [SIZE_W-1:0]     w_eff, h_eff;
    logic                  row_end, cell_end;

    // emission logic
    logic [NUM_COLORS-1:0] iso;
    logic [AW-1:0]         low_idx;
    logic [SUM_W:0]        sum_ext;

    // RAM
    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_raddr;
    logic [RAM_W-1:0] ram_wdata, ram_rdata;
    logic [PCNT_W-1:0] old_pix;
    logic [CCNT_W-1:0] old_col;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (v > SIZE_W'(MAX_CELL_SIZE)) begin
            r = SIZE_W'(MAX_CELL_SIZE);
        end else begin
            r = v;
        end
        return r;
    endfunction

    assign w_eff = clamp_size(width_reg);
    assign h_eff = clamp_size(height_reg);

    assign pix      = s_tdata[PIX_W-1:0];
    assign pix_addr = pix[AW-1:0];
    assign clr      = s_tuser;
    assign counted  = (pix != bg_reg) && (7'(pix) < 7'(NUM_COLORS));
    assign pix_bit  = counted ? (NUM_COLORS'(1) << pix_addr) : '0;

    // image start drops the partial cell before this pixel is counted
    assign cell_base = clr ? '0 : cell_pres_reg;
    assign col_base  = clr ? '0 : col_pres_reg;
    assign cnt_base  = clr ? '0 : cell_cnt_reg;
    assign row_base  = clr ? '0 : row_reg;
    assign colc_base = clr ? '0 : colc_reg;

    assign new_cell = counted && !cell_base[pix_addr];
    assign new_col  = counted && !col_base[pix_addr];
    assign row_end  = !((6'(row_base) + 6'd1) < 6'(h_eff));
    assign cell_end = row_end && !((6'(colc_base) + 6'd1) < 6'(w_eff));

    // lowest pending color of the cell
    assign iso = cell_pres_reg & (~cell_pres_reg + NUM_COLORS'(1));

    always_comb begin
        low_idx = '0;
        for (int i = 0; i < NUM_COLORS; i++) begin
            if (iso[i]) begin
                low_idx = low_idx | AW'(i);
            end
        end
    end

    assign sum_ext = {1'b0, sum_reg} + (SUM_W + 1)'(cell_cnt_reg);

    // next state of the cell and image registers
    always_comb begin
        row_next       = row_reg;
        colc_next      = colc_reg;
        col_pres_next  = col_pres_reg;
        cell_pres_next = cell_pres_reg;
        cell_cnt_next  = cell_cnt_reg;
        img_pres_next  = img_pres_reg;
        max_next       = max_reg;
        sum_next       = sum_reg;
        if (cmd.pix_accept) begin
            cell_pres_next = cell_base | pix_bit;
            col_pres_next  = row_end ? '0 : (col_base | pix_bit);
            cell_cnt_next  = cnt_base + NCOL_W'(new_cell);
            row_next       = row_end ? '0 : row_base + CNT_W'(1);
            if (row_end) begin
                colc_next = cell_end ? '0 : colc_base + CNT_W'(1);
            end else begin
                colc_next = colc_base;
            end
            if (clr) begin
                img_pres_next = '0;
                max_next      = '0;
                sum_next      = '0;
            end
        end
        if (cmd.cell_stats) begin
            max_next      = (cell_cnt_reg > max_reg) ? cell_cnt_reg : max_reg;
            sum_next      = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
            img_pres_next = img_pres_reg | cell_pres_reg;
        end
        if (cmd.emit_read) begin
            // drop the emitted color from the pending set
            cell_pres_next = cell_pres_reg & ~iso;
        end
        if (cmd.emit_load && emit_last_reg) begin
            cell_cnt_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bg_reg        <= '0;
            width_reg     <= CELL_SIZE_RESET;
            height_reg    <= CELL_SIZE_RESET;
            row_reg       <= '0;
            colc_reg      <= '0;
            col_pres_reg  <= '0;
            cell_pres_reg <= '0;
            cell_cnt_reg  <= '0;
            img_pres_reg  <= '0;
            max_reg       <= '0;
            sum_reg       <= '0;
            counted_reg   <= 1'b0;
            new_cell_reg  <= 1'b0;
            new_col_reg   <= 1'b0;
            cell_end_reg  <= 1'b0;
            emit_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_BACKGROUND:  bg_reg     <= cfg_wdata;
                    REG_CELL_WIDTH:  width_reg  <= cfg_wdata[SIZE_W-1:0];
                    REG_CELL_HEIGHT: height_reg <= cfg_wdata[SIZE_W-1:0];
                    default: begin
                    end
                endcase
            end
            row_reg       <= row_next;
            colc_reg      <= colc_next;
            col_pres_reg  <= col_pres_next;
            cell_pres_reg <= cell_pres_next;
            cell_cnt_reg  <= cell_cnt_next;
            img_pres_reg  <= img_pres_next;
            max_reg       <= max_next;
            sum_reg       <= sum_next;
            if (cmd.pix_accept) begin
                counted_reg  <= counted;
                new_cell_reg <= new_cell;
                new_col_reg  <= new_col;
                cell_end_reg <= cell_end;
            end
            if (cmd.emit_read) begin
                emit_last_reg <= ((cell_pres_reg & ~iso) == '0);
            end
            if (cmd.emit_load || cmd.empty_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.pix_accept) begin
            pix_idx_reg <= pix_addr;
        end
        if (cmd.emit_read) begin
            emit_color_reg <= low_idx;
        end
        if (cmd.emit_load) begin
            out_color_reg  <= PIX_W'(emit_color_reg);
            out_cvalid_reg <= 1'b1;
            out_pix_reg    <= ram_rdata[RAM_W-1:CCNT_W];
            out_col_reg    <= ram_rdata[CCNT_W-1:0];
            out_ccount_reg <= cell_cnt_reg;
            out_max_reg    <= max_reg;
            out_sum_reg    <= sum_reg;
            out_mask_reg   <= MASK_W'(img_pres_reg);
            out_last_reg   <= emit_last_reg;
        end else if (cmd.empty_load) begin
            out_color_reg  <= '0;
            out_cvalid_reg <= 1'b0;
            out_pix_reg    <= '0;
            out_col_reg    <= '0;
            out_ccount_reg <= '0;
            out_max_reg    <= max_reg;
            out_sum_reg    <= sum_reg;
            out_mask_reg   <= MASK_W'(img_pres_reg);
            out_last_reg   <= 1'b1;
        end
    end

    // histogram RAM: read on intake or emission, write back in the cycle after intake
    assign old_pix   = ram_rdata[RAM_W-1:CCNT_W];
    assign old_col   = ram_rdata[CCNT_W-1:0];
    assign ram_re    = cmd.pix_accept || cmd.emit_read;
    assign ram_raddr = cmd.emit_read ? low_idx : pix_addr;
    assign ram_we    = cmd.pix_write && counted_reg;

    always_comb begin
        if (new_cell_reg) begin
            // entry is stale until the color enters the cell
            ram_wdata = {PCNT_W'(1), CCNT_W'(1)};
        end else begin
            ram_wdata = {(old_pix == '1) ? old_pix : old_pix + PCNT_W'(1),
                         (new_col_reg && old_col != '1) ? old_col + CCNT_W'(1) : old_col};
        end
    end

    tcs_ram #(
        .WIDTH (RAM_W),
        .DEPTH (NUM_COLORS)
    ) u_hist_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (pix_idx_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign status.cell_end   = cell_end_reg;
    assign status.cell_empty = (cell_cnt_reg == '0);
    assign status.out_free   = !out_valid_reg || m_tready;
    assign status.emit_last  = emit_last_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_cvalid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {PAD_W'(0), out_mask_reg, out_sum_reg, out_max_reg, out_ccount_reg,
                       out_col_reg, out_pix_reg, out_color_reg};

    `TCS_ASSERT_ALWAYS(a_cnt_covers_pending, aclk, aresetn,
        cell_cnt_reg >= NCOL_W'($countones(cell_pres_reg)),
        "cell color count below pending colors")

    `TCS_ASSERT_IMPLY(a_pix_ge_col, aclk, aresetn, out_valid_reg && out_cvalid_reg,
        (out_pix_reg >= PCNT_W'(out_col_reg)) && (out_col_reg != '0),
        "column count inconsistent with pixel count")

    `TCS_ASSERT_IMPLY(a_max_ge_cell, aclk, aresetn, out_valid_reg,
        out_max_reg >= out_ccount_reg,
        "running maximum below cell color count")

endmodule

/* rtl/core/tile_color_statistics.sv */
// Pixel intake: accept a pixel while reading its histogram RAM entry, then write the updated entry back.
// Cell end: a statistics step, then per present color a RAM read and an output load,
// or one empty-cell result for an empty cell; each load waits for a free output register.
// Intake resumes once the last result sits in the output register.
// Reset (aresetn low, synchronous) clears counters, masks, statistics and config to defaults;
// histogram RAM is not cleared, entries are qualified by the cell presence mask.
module tile_color_statistics #(
    parameter int NUM_COLORS    = tcs_pkg::NUM_COLORS_DEF,
    parameter int MAX_CELL_SIZE = tcs_pkg::MAX_CELL_SIZE_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [tcs_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [tcs_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tcs_pkg::S_TDATA_W-1:0] s_tdata,   // pixel_color
    input  logic                          s_tuser,   // image_start
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // color, pixel_count, column_count, cell_color_count, max_colors_so_far,
    // colors_sum_so_far, image_color_mask
    output logic [tcs_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tuser,   // color_valid
    output logic                          m_tlast
);

    import tcs_pkg::*;

    tcs_cmd_t    cmd;
    tcs_status_t status;

    tcs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tcs_datapath #(
        .NUM_COLORS    (NUM_COLORS),
        .MAX_CELL_SIZE (MAX_CELL_SIZE)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
